FILE: sv/assert_macros.svh
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/bfrp_pkg.sv
// types and constants of the best-fit rectangle packer
`timescale 1ns / 1ps
package bfrp_pkg;

  localparam int COORD_BITS     = 15;
  localparam int MAX_OPEN_RECTS = 64;
  localparam int OPEN_IDX_BITS  = $clog2(MAX_OPEN_RECTS);
  localparam int OPEN_CNT_BITS  = OPEN_IDX_BITS + 1;
  localparam int ALLOC_BITS     = 16;
  localparam int AREA_BITS      = 2 * COORD_BITS;
  localparam int CFG_IDX_BITS   = 2;
  localparam int ATLAS_RESET    = 1024;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_HEIGHT = CFG_IDX_BITS'(1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    logic [14:0] req_width;
    logic [14:0] req_height;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] alloc_index;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
  } res_t;

  typedef struct packed {
    logic                     vld;
    logic [OPEN_IDX_BITS-1:0] idx;
    rect_t                    rect;
  } cand_t;

  typedef struct packed {
    logic                     found;
    logic [OPEN_IDX_BITS-1:0] idx;
    rect_t                    rect;
  } best_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PLACE,
    S_APPEND,
    S_DONE
  } state_t;

endpackage

FILE: sv/bfrp_best_sel.sv
// fit test, area and smallest-area selection over streamed open rectangles
`timescale 1ns / 1ps
module bfrp_best_sel import bfrp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   clear,
  input  coord_t req_w,
  input  coord_t req_h,
  input  cand_t  cand,
  output best_t  best
);

  logic                     p_vld;
  logic                     p_fit;
  logic [AREA_BITS-1:0]     p_area;
  logic [OPEN_IDX_BITS-1:0] p_idx;
  rect_t                    p_rect;
  logic [AREA_BITS-1:0]     best_area;
  logic                     take;

  assign take = p_vld && p_fit && (!best.found || p_area < best_area);

  always_ff @(posedge clk) begin
    p_fit  <= (req_w <= cand.rect.w) && (req_h <= cand.rect.h);
    p_area <= AREA_BITS'(cand.rect.w) * AREA_BITS'(cand.rect.h);
    p_idx  <= cand.idx;
    p_rect <= cand.rect;
    if (take) begin
      best.idx  <= p_idx;
      best.rect <= p_rect;
      best_area <= p_area;
    end
    if (rst) begin
      p_vld      <= 1'b0;
      best.found <= 1'b0;
    end else begin
      p_vld <= cand.vld && !clear;
      if (clear) begin
        best.found <= 1'b0;
      end else if (take) begin
        best.found <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/best_fit_rect_packer_core.sv
// best-fit guillotine rectangle packer, top level
// the scan reads one list entry per cycle; after acceptance the whole open list is scanned,
// the selection drains, the best rectangle is placed and a successful split appends its
// lower part; the result then loads into the output register once that is free or draining
// a further item is accepted in idle after that load, while no configuration is pending
// reset: atlas 1024 x 1024, one open rectangle, allocation index zero; no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module best_fit_rect_packer_core import bfrp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  req_t                    in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output res_t                    out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [14:0]             cfg_data
);

  state_t                   state, state_next;
  req_t                     req;
  logic [OPEN_CNT_BITS-1:0] open_count;
  logic [OPEN_CNT_BITS-1:0] scan_idx;
  logic [ALLOC_BITS:0]      next_index;
  coord_t                   atlas_w, atlas_h;
  logic                     fresh;
  logic                     drain_cnt;
  rect_t                    mem [MAX_OPEN_RECTS];
  rect_t                    rd_q;
  logic                     rd_vld;
  logic [OPEN_IDX_BITS-1:0] rd_idx;
  cand_t                    cand;
  best_t                    best;
  res_t                     res;

  logic                     in_txn, cfg_txn, scan_last;
  logic                     fit_w, fit_h, split, fail;
  rect_t                    mod_rect, below, atlas_rect;
  logic                     rd_en, mem_we, load_out;
  logic [OPEN_IDX_BITS-1:0] waddr;
  rect_t                    wdata;

  assign in_txn    = in_valid && in_ready;
  assign cfg_txn   = cfg_valid && cfg_ready;
  assign scan_last = (scan_idx + OPEN_CNT_BITS'(1)) == open_count;

  assign atlas_rect = '{x: '0, y: '0, w: atlas_w, h: atlas_h};

  always_comb begin
    cand.vld  = rd_vld;
    cand.idx  = rd_idx;
    cand.rect = (rd_idx == '0 && fresh) ? atlas_rect : rd_q;
  end

  bfrp_best_sel u_sel (
    .clk   (clk),
    .rst   (rst),
    .clear (in_txn),
    .req_w (req.req_width),
    .req_h (req.req_height),
    .cand  (cand),
    .best  (best)
  );

  // split of the chosen rectangle
  always_comb begin
    fit_w    = req.req_width == best.rect.w;
    fit_h    = req.req_height == best.rect.h;
    split    = !fit_w && !fit_h;
    fail     = !best.found || next_index[ALLOC_BITS] ||
               (split && open_count == OPEN_CNT_BITS'(MAX_OPEN_RECTS));
    mod_rect = best.rect;
    below.x  = best.rect.x;
    below.y  = best.rect.y + req.req_height;
    below.w  = req.req_width;
    below.h  = best.rect.h - req.req_height;
    if (fit_w && fit_h) begin
      mod_rect.w = '0;
      mod_rect.h = '0;
    end else if (fit_w) begin
      mod_rect.y = best.rect.y + req.req_height;
      mod_rect.h = best.rect.h - req.req_height;
    end else begin
      mod_rect.x = best.rect.x + req.req_width;
      mod_rect.w = best.rect.w - req.req_width;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_txn) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_cnt) state_next = S_PLACE;
      end
      S_PLACE: begin
        state_next = (!fail && split) ? S_APPEND : S_DONE;
      end
      S_APPEND: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    waddr     = best.idx;
    wdata     = mod_rect;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_PLACE: begin
        mem_we = !fail;
      end
      S_APPEND: begin
        mem_we = 1'b1;
        waddr  = open_count[OPEN_IDX_BITS-1:0];
        wdata  = below;
      end
      S_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // list memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (rd_en) rd_q <= mem[scan_idx[OPEN_IDX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[OPEN_IDX_BITS-1:0];
    if (in_txn) req <= in_data;
    if (state == S_PLACE) begin
      if (fail) res <= '0;
      else res <= '{ok: 1'b1, alloc_index: next_index[ALLOC_BITS-1:0],
                    pos_x: best.rect.x, pos_y: best.rect.y};
    end
    if (load_out) out_data <= res;
    if (rst) begin
      state      <= S_IDLE;
      open_count <= OPEN_CNT_BITS'(1);
      next_index <= '0;
      atlas_w    <= COORD_BITS'(ATLAS_RESET);
      atlas_h    <= COORD_BITS'(ATLAS_RESET);
      fresh      <= 1'b1;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      scan_idx   <= '0;
      drain_cnt  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (cfg_txn && cfg_index == CFG_ATLAS_WIDTH) begin
        atlas_w    <= cfg_data;
        fresh      <= 1'b1;
        open_count <= OPEN_CNT_BITS'(1);
      end
      if (cfg_txn && cfg_index == CFG_ATLAS_HEIGHT) begin
        atlas_h    <= cfg_data;
        fresh      <= 1'b1;
        open_count <= OPEN_CNT_BITS'(1);
      end
      if (in_txn) scan_idx <= '0;
      if (state == S_SCAN) begin
        scan_idx  <= scan_idx + OPEN_CNT_BITS'(1);
        drain_cnt <= 1'b0;
      end
      if (state == S_DRAIN) drain_cnt <= 1'b1;
      if (state == S_PLACE && !fail) next_index <= next_index + (ALLOC_BITS + 1)'(1);
      if (mem_we && waddr == '0) fresh <= 1'b0;
      if (state == S_APPEND) open_count <= open_count + OPEN_CNT_BITS'(1);
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `ASSERT_CHK(a_count_range, open_count != '0 && open_count <= OPEN_CNT_BITS'(MAX_OPEN_RECTS), "open count out of range")
  `ASSERT_CHK(a_scan_bound, state != S_SCAN || scan_idx < open_count, "scan past end of list")
  `ASSERT_CHK(a_append_room, state != S_APPEND || open_count < OPEN_CNT_BITS'(MAX_OPEN_RECTS), "append into full list")
  `ASSERT_NEXT(a_index_step, state == S_PLACE && !fail, next_index == $past(next_index) + (ALLOC_BITS + 1)'(1), "index not advanced")
  `ASSERT_NEXT(a_out_from_done, !out_valid, !out_valid || $past(state == S_DONE), "result loaded outside done")

endmodule
